>>> src/dedup_priority_request_queue_assert.svh
// Assertion macros for the request queue
`ifndef DEDUP_PRIORITY_REQUEST_QUEUE_ASSERT_SVH
`define DEDUP_PRIORITY_REQUEST_QUEUE_ASSERT_SVH
`define DPRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define DPRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> src/dprq_pkg.sv
package dprq_pkg;
  localparam logic [2:0] CMD_ENQ    = 3'd0;
  localparam logic [2:0] CMD_TAKE   = 3'd1;
  localparam logic [2:0] CMD_RETRY  = 3'd2;
  localparam logic [2:0] CMD_CANCEL = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [3:0] ST_REJECTED  = 4'd0;
  localparam logic [3:0] ST_QUEUED    = 4'd1;
  localparam logic [3:0] ST_ALREADY   = 4'd2;
  localparam logic [3:0] ST_REPLACED  = 4'd3;
  localparam logic [3:0] ST_FULL      = 4'd4;
  localparam logic [3:0] ST_EMPTY     = 4'd5;
  localparam logic [3:0] ST_WAITING   = 4'd6;
  localparam logic [3:0] ST_READY     = 4'd7;
  localparam logic [3:0] ST_RFAILED   = 4'd8;
  localparam logic [3:0] ST_RCANCEL   = 4'd9;
  localparam logic [3:0] ST_RSCHED    = 4'd10;
  localparam logic [3:0] ST_CANCELLED = 4'd11;
  localparam logic [3:0] ST_CLEARED   = 4'd12;

  localparam logic [7:0] ATTEMPT_LIMIT_RESET = 8'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] day_key;
    logic [3:0]  artifact_kind;
    logic [31:0] span_start;
    logic [31:0] span_end;
    logic [7:0]  key_revision;
    logic        urgent;
    logic [31:0] generation;
    logic [31:0] ticket_number;
    logic [7:0]  prior_attempts;
    logic [31:0] now_ms;
    logic [31:0] backoff_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] out_ticket;
    logic [31:0] out_generation;
    logic [31:0] out_day;
    logic [3:0]  out_kind;
    logic [31:0] out_start;
    logic [31:0] out_end;
    logic [7:0]  out_revision;
    logic        out_urgent;
    logic [7:0]  out_attempts;
    logic [31:0] out_ready_at;
    logic [4:0]  removed_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] day;
    logic [3:0]  kind;
    logic [31:0] start;
    logic [31:0] stop;
    logic [7:0]  revision;
    logic [31:0] ticket;
    logic [31:0] generation;
    logic        urgent;
    logic [7:0]  attempts;
    logic [31:0] ready_at;
  } entry_t;

  // Per-cell control.
  typedef struct packed {
    logic shift;      // take the neighbour's entry
    logic load;       // take the shared load entry
  } cell_ctl_t;
endpackage

>>> src/dprq_cell.sv
module dprq_cell
  import dprq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    from_next,
  input  entry_t    load_data,
  output entry_t    held
);
  entry_t data;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= from_next;
    end else if (ctl.load) begin
      data <= load_data;
    end
  end

  assign held = data;
endmodule

>>> src/dedup_priority_request_queue.sv
// channel  direction  handshake             word
// req      in         start / busy          req (req_t)
// rsp      out        rsp_valid strobe      rsp (rsp_t)
// cfg      in         cfg_valid / cfg_ready cfg_data (attempt limit)
// Enqueue, retry, cancel and a take with nothing ready walk the chain once,
// head popped and re-pushed at the tail unless dropped.
// A take that finds an entry walks twice (search, then remove).
// Clear, rejected or refused commands and a take on an empty table skip the walk.
// The result strobe comes in the same cycle that busy falls and cannot be stalled.
// Reset empties the table, sets the ticket counter to one and the limit to 3.
module dedup_priority_request_queue
  import dprq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       rsp_valid,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] occ;
  logic [CW-1:0] step;
  logic [CW-1:0] span;
  logic          second;
  logic [31:0]   tcount;
  logic [7:0]    limit;
  req_t          r;
  logic          found, hit_dup;
  logic          fg_found, bg_found;
  logic [IW-1:0] fg_pos, bg_pos, pick_pos;
  logic [4:0]    removed;
  rsp_t          res;
  rsp_t          start_res;
  logic          quick;

  entry_t    cells [CAPACITY];
  entry_t    head;
  entry_t    new_entry;
  entry_t    recirc;
  entry_t    load_data;
  logic      live, walking, key_eq, dup_now, ready_ok, drop_head, append_now;
  logic [31:0] diff, ready_sum;
  logic [31:0] tk_issue, tk_after;

  assign head = cells[0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= ATTEMPT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // Head of the chain is original entry 'step' during a walk.
  always_comb begin
    live     = (step != span);
    walking  = (state == S_WALK) && live;
    key_eq   = head.day == r.day_key && head.kind == r.artifact_kind &&
               head.start == r.span_start && head.stop == r.span_end;
    dup_now  = head.revision == r.key_revision && head.generation == r.generation;
    diff     = r.now_ms - head.ready_at;
    ready_ok = (head.ready_at == 32'd0) || !diff[31];
    drop_head = 1'b0;
    if (walking) begin
      unique case (r.cmd)
        CMD_ENQ:    drop_head = key_eq && !found && !dup_now;
        CMD_CANCEL: drop_head = (head.generation == r.generation);
        CMD_TAKE:   drop_head = second && (step[IW-1:0] == pick_pos);
        default:    drop_head = 1'b0;
      endcase
    end
    recirc = head;
    if (r.cmd == CMD_ENQ && key_eq && !found && dup_now && r.urgent) begin
      recirc.urgent = 1'b1;
    end
  end

  always_comb begin
    tk_issue = (tcount == 32'd0) ? tcount + 32'd1 : tcount;
    tk_after = (tcount == 32'd0) ? tcount + 32'd2 : tcount + 32'd1;
  end

  always_comb begin
    ready_sum = r.now_ms + r.backoff_ms;
    new_entry.day = r.day_key;
    new_entry.kind = r.artifact_kind;
    new_entry.start = r.span_start;
    new_entry.stop = r.span_end;
    new_entry.revision = r.key_revision;
    new_entry.generation = r.generation;
    new_entry.urgent = r.urgent;
    if (r.cmd == CMD_RETRY) begin
      new_entry.ticket = r.ticket_number;
      new_entry.attempts = r.prior_attempts + 8'd1;
      new_entry.ready_at = (r.backoff_ms == 32'd0) ? 32'd0 :
                           (ready_sum == 32'd0) ? 32'd1 : ready_sum;
    end else begin
      new_entry.ticket = tk_issue;
      new_entry.attempts = 8'd0;
      new_entry.ready_at = 32'd0;
    end
  end

  assign append_now = (state == S_DEC) &&
                      ((r.cmd == CMD_ENQ && !hit_dup && occ < CW'(CAPACITY)) ||
                       (r.cmd == CMD_RETRY && !found));
  assign load_data = append_now ? new_entry : recirc;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      localparam logic [CW-1:0] POS  = CW'(g);
      localparam logic [CW-1:0] POS1 = CW'(g + 1);
      entry_t    nb;
      cell_ctl_t cctl;
      if (g == CAPACITY - 1) begin : g_last
        assign nb = '0;
      end else begin : g_mid
        assign nb = cells[g+1];
      end
      assign cctl.shift = walking && (POS1 < occ);
      assign cctl.load  = (walking && !drop_head && POS1 == occ) ||
                          (append_now && POS == occ);
      dprq_cell u_cell (
        .clk      (clk),
        .ctl      (cctl),
        .from_next(nb),
        .load_data(load_data),
        .held     (cells[g])
      );
    end
  endgenerate

  // Commands answered without a walk.
  always_comb begin
    start_res = '0;
    quick = 1'b1;
    if (req.cmd == CMD_CLEAR) begin
      start_res.status = ST_CLEARED;
    end else if (req.cmd > CMD_CLEAR) begin
      start_res.status = ST_REJECTED;
    end else if (req.cmd == CMD_ENQ &&
                 (req.artifact_kind == 4'd0 || req.generation == 32'd0)) begin
      start_res.status = ST_REJECTED;
    end else if (req.cmd == CMD_RETRY &&
                 (req.artifact_kind == 4'd0 || req.ticket_number == 32'd0 ||
                  req.prior_attempts >= limit || occ >= CW'(CAPACITY))) begin
      start_res.status = ST_RFAILED;
    end else if (req.cmd == CMD_TAKE && occ == '0) begin
      start_res.status = ST_EMPTY;
    end else begin
      quick = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ <= '0;
      tcount <= 32'd1;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            step <= '0;
            span <= occ;
            second <= 1'b0;
            found <= 1'b0;
            hit_dup <= 1'b0;
            fg_found <= 1'b0;
            bg_found <= 1'b0;
            removed <= '0;
            res <= start_res;
            if (req.cmd == CMD_CLEAR) occ <= '0;
            state <= quick ? S_DONE : S_WALK;
          end
        end
        S_WALK: begin
          if (live) begin
            step <= step + CW'(1);
            if (drop_head) occ <= occ - CW'(1);
            if ((r.cmd == CMD_ENQ || r.cmd == CMD_RETRY) && key_eq && !found) begin
              found <= 1'b1;
              hit_dup <= dup_now;
              if (r.cmd == CMD_ENQ && dup_now) begin
                res.out_ticket <= head.ticket;
                res.out_generation <= head.generation;
              end
            end
            if (r.cmd == CMD_CANCEL && drop_head) removed <= removed + 5'd1;
            if (r.cmd == CMD_TAKE && !second) begin
              if (!fg_found && head.urgent && ready_ok) begin
                fg_found <= 1'b1;
                fg_pos <= step[IW-1:0];
              end
              if (!bg_found && !head.urgent && ready_ok) begin
                bg_found <= 1'b1;
                bg_pos <= step[IW-1:0];
              end
            end
            if (r.cmd == CMD_TAKE && drop_head) begin
              res.status <= ST_READY;
              res.out_ticket <= head.ticket;
              res.out_generation <= head.generation;
              res.out_day <= head.day;
              res.out_kind <= head.kind;
              res.out_start <= head.start;
              res.out_end <= head.stop;
              res.out_revision <= head.revision;
              res.out_urgent <= head.urgent;
              res.out_attempts <= head.attempts;
              res.out_ready_at <= head.ready_at;
            end
          end else begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          unique case (r.cmd)
            CMD_ENQ: begin
              state <= S_DONE;
              if (hit_dup) begin
                res.status <= ST_ALREADY;
              end else if (occ >= CW'(CAPACITY)) begin
                res.status <= ST_FULL;
              end else begin
                res.status <= found ? ST_REPLACED : ST_QUEUED;
                res.out_ticket <= tk_issue;
                res.out_generation <= r.generation;
                tcount <= tk_after;
                occ <= occ + CW'(1);
              end
            end
            CMD_RETRY: begin
              state <= S_DONE;
              if (found) begin
                res.status <= ST_RCANCEL;
              end else begin
                res.status <= ST_RSCHED;
                occ <= occ + CW'(1);
              end
            end
            CMD_CANCEL: begin
              state <= S_DONE;
              res.status <= ST_CANCELLED;
              res.removed_count <= removed;
            end
            CMD_TAKE: begin
              if (!second && (fg_found || bg_found)) begin
                pick_pos <= fg_found ? fg_pos : bg_pos;
                second <= 1'b1;
                step <= '0;
                state <= S_WALK;
              end else begin
                state <= S_DONE;
                if (!second) res.status <= ST_WAITING;
              end
            end
            default: begin
              state <= S_DONE;
              res.status <= ST_REJECTED;
            end
          endcase
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign rsp = res;
endmodule

>>> src/dprq_checker.sv
module dprq_checker
  import dprq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic rsp_valid,
  input rsp_t rsp
);
`include "dedup_priority_request_queue_assert.svh"
  `DPRQ_ASSERT_NXT(a_start_busy, start && !busy, busy, "start not taken")
  `DPRQ_ASSERT_IMP(a_rsp_busy, rsp_valid, !busy, "result while busy")
  `DPRQ_ASSERT_NXT(a_rsp_pulse, rsp_valid, !rsp_valid, "result repeated")
  `DPRQ_ASSERT_IMP(a_status, rsp_valid, rsp.status <= ST_CLEARED, "bad status")
endmodule

bind dedup_priority_request_queue dprq_checker u_dprq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .rsp_valid(rsp_valid), .rsp(rsp)
);
